// ----- rtl/transport_receive_window_acker_assert.svh -----
// Assertion macros used by the acknowledger's checker
`ifndef TRANSPORT_RECEIVE_WINDOW_ACKER_ASSERT_SVH
`define TRANSPORT_RECEIVE_WINDOW_ACKER_ASSERT_SVH

// Clocked assertion, quiet while reset is held
`define TRWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds through reset
`define TRWA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/trwa_pkg.sv -----
// Shared types and status codes of the receive window acknowledger
package trwa_pkg;

  typedef logic [3:0] status_t;

  // Result status codes
  localparam status_t StSynAck    = 4'd0;
  localparam status_t StNew       = 4'd1;
  localparam status_t StDup       = 4'd2;
  localparam status_t StOutWindow = 4'd3;
  localparam status_t StHsIgnored = 4'd4;
  localparam status_t StBadSum    = 4'd5;
  localparam status_t StForeign   = 4'd6;
  localparam status_t StWaiting   = 4'd7;
  localparam status_t StClosed    = 4'd8;
  localparam status_t StAfterDone = 4'd9;

  localparam int unsigned SeqW   = 31;
  localparam int unsigned IsnW   = 14;
  localparam int unsigned StampW = 63;
  localparam int unsigned DupW   = 32;

  // Window update command
  typedef struct packed {
    logic clear;  // drop every mark
    logic mark;   // set the indexed mark and slide over the completed run
  } win_ctl_t;

endpackage

// ----- rtl/trwa_window.sv -----
// Receive bitmap above the contiguous point, with trailing-run find and slide
module trwa_window
  import trwa_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  win_ctl_t                           ctl_i,
  input  logic [$clog2(WINDOW)-1:0]          idx_i,
  output logic                               hit_o,
  output logic [$clog2(WINDOW+1)-1:0]        run_o
);

  localparam int unsigned RunW = $clog2(WINDOW + 1);

  logic [WINDOW-1:0] win_q, win_d;
  logic [WINDOW-1:0] marked;
  logic [WINDOW-1:0] first_gap;
  logic [RunW-1:0]   run;

  assign hit_o  = win_q[idx_i];
  assign marked = win_q | ({{(WINDOW-1){1'b0}}, 1'b1} << idx_i);
  // one-hot of the lowest clear bit; zero when the whole window is marked
  assign first_gap = ~marked & (marked + WINDOW'(1));

  // encode the run length of marks from the bottom
  always_comb begin
    run = '0;
    for (int unsigned i = 0; i < WINDOW; i++) begin
      if (first_gap[i]) begin
        run = run | RunW'(i);
      end
    end
    if (first_gap == '0) begin
      run = RunW'(WINDOW);
    end
  end

  assign run_o = run;

  // clear, or mark and slide the completed run out
  always_comb begin
    win_d = win_q;
    if (ctl_i.clear) begin
      win_d = '0;
    end else if (ctl_i.mark) begin
      win_d = marked >> run;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

endmodule

// ----- rtl/transport_receive_window_acker.sv -----
// Receive window acknowledger: a packet header or a receive timeout enters as one
// word and leaves as one result word. An accepted word lands in an input register
// and is processed from there into the result register once that register is empty
// or being drained; the block takes one word every cycle as long as results are
// drained. That rate rests on the window update:
// decoding the offset, marking the bitmap, finding the trailing run and sliding
// it out all happen between the input and result registers. The bitmap of WINDOW
// marks is cleared by reset at once, with no clearing pass. The initial sequence
// number register is written through the configuration channel, always ready.
module transport_receive_window_acker
  import trwa_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [13:0] cfg_data_i,
  // event words in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [31:0] source_address_i,
  input  logic [15:0] source_port_i,
  input  logic [30:0] seq_number_i,
  input  logic [30:0] ack_number_i,
  input  logic        syn_flag_i,
  input  logic        ack_flag_i,
  input  logic        fin_flag_i,
  input  logic        checksum_ok_i,
  input  logic [62:0] send_stamp_i,
  // result words out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        send_ack_o,
  output logic        reply_syn_o,
  output logic        reply_fin_o,
  output logic [30:0] reply_seqno_o,
  output logic [30:0] reply_ackno_o,
  output logic [62:0] stamp_echo_o,
  output logic [3:0]  status_o,
  output logic [31:0] duplicate_total_o
);

  localparam int unsigned IdxW = $clog2(WINDOW);
  localparam int unsigned RunW = $clog2(WINDOW + 1);
  localparam logic [SeqW-1:0] WinLen = SeqW'(WINDOW);

  // configuration register
  logic [IsnW-1:0] isn_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isn_q <= '0;
    end else if (cfg_valid_i) begin
      isn_q <= cfg_data_i;
    end
  end

  // input register
  logic              in_valid_q;
  logic              op_q;
  logic [31:0]       saddr_q;
  logic [15:0]       sport_q;
  logic [SeqW-1:0]   seq_q;
  logic [SeqW-1:0]   ackn_q;
  logic              syn_q, ackf_q, finf_q, sum_ok_q;
  logic [StampW-1:0] stamp_q;
  logic              go;

  assign go         = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q     <= op_i;
      saddr_q  <= source_address_i;
      sport_q  <= source_port_i;
      seq_q    <= seq_number_i;
      ackn_q   <= ack_number_i;
      syn_q    <= syn_flag_i;
      ackf_q   <= ack_flag_i;
      finf_q   <= fin_flag_i;
      sum_ok_q <= checksum_ok_i;
      stamp_q  <= send_stamp_i;
    end
  end

  // connection state
  logic            hs_q, hs_d;
  logic            seen_q, seen_d;
  logic            done_q, done_d;
  logic [31:0]     peer_addr_q, peer_addr_d;
  logic [15:0]     peer_port_q, peer_port_d;
  logic            base_q, base_d;
  logic [SeqW-1:0] contig_q, contig_d;
  logic            fin_valid_q, fin_valid_d;
  logic [SeqW-1:0] fin_num_q, fin_num_d;
  logic [DupW-1:0] dup_q, dup_d;

  // window lookup
  logic [SeqW-1:0] seq_delta;
  logic [SeqW-1:0] off;
  logic            hit;
  logic [RunW-1:0] run;
  win_ctl_t        win_ctl;

  assign seq_delta = seq_q - contig_q;
  assign off       = seq_delta - SeqW'(1);

  trwa_window #(
    .WINDOW(WINDOW)
  ) u_window (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (win_ctl),
    .idx_i (off[IdxW-1:0]),
    .hit_o (hit),
    .run_o (run)
  );

  // result of the word in the input register
  logic              r_ack, r_syn, r_fin;
  logic [SeqW-1:0]   r_seqno, r_ackno;
  logic [StampW-1:0] r_stamp;
  status_t           r_status;
  logic              foreign;
  logic              complete;

  assign foreign = (saddr_q != peer_addr_q) || (sport_q != peer_port_q);

  always_comb begin
    hs_d        = hs_q;
    seen_d      = seen_q;
    done_d      = done_q;
    peer_addr_d = peer_addr_q;
    peer_port_d = peer_port_q;
    base_d      = base_q;
    contig_d    = contig_q;
    fin_valid_d = fin_valid_q;
    fin_num_d   = fin_num_q;
    dup_d       = dup_q;
    win_ctl     = '0;
    complete    = 1'b0;
    r_ack       = 1'b0;
    r_syn       = 1'b0;
    r_fin       = 1'b0;
    r_seqno     = '0;
    r_ackno     = '0;
    r_stamp     = '0;
    r_status    = StAfterDone;

    if (done_q) begin
      r_status = StAfterDone;
    end else if (op_q) begin
      // receive timeout
      if (!seen_q) begin
        r_status = StWaiting;
      end else begin
        done_d   = 1'b1;
        r_status = StClosed;
      end
    end else begin
      seen_d = 1'b1;
      if (syn_q) begin
        if (foreign && !hs_q) begin
          // abort on a SYN from another sender once the handshake is over
          done_d   = 1'b1;
          r_status = StForeign;
        end else begin
          if (foreign) begin
            peer_addr_d = saddr_q;
            peer_port_d = sport_q;
          end
          r_ack    = 1'b1;
          r_syn    = 1'b1;
          r_seqno  = base_q ? contig_q : SeqW'(isn_q);
          r_ackno  = seq_q;
          r_stamp  = stamp_q;
          r_status = StSynAck;
        end
      end else if (!sum_ok_q) begin
        r_status = StBadSum;
      end else if (hs_q && (!ackf_q || ackn_q != SeqW'(isn_q))) begin
        r_status = StHsIgnored;
      end else begin
        hs_d = 1'b0;
        // place the data seqno against the window
        if (!base_q) begin
          base_d        = 1'b1;
          contig_d      = seq_q;
          win_ctl.clear = 1'b1;
          r_status      = StNew;
        end else if (seq_q <= contig_q) begin
          r_status = StDup;
        end else if (off >= WinLen) begin
          r_status = StOutWindow;
        end else if (hit) begin
          r_status = StDup;
        end else begin
          win_ctl.mark = 1'b1;
          contig_d     = contig_q + SeqW'(run);
          r_status     = StNew;
        end

        if (r_status == StDup && dup_q != '1) begin
          dup_d = dup_q + DupW'(1);
        end
        if (finf_q) begin
          fin_valid_d = 1'b1;
          fin_num_d   = seq_q;
        end
        complete = fin_valid_d && (contig_d == fin_num_d);
        if (complete) begin
          done_d = 1'b1;
        end
        r_ack   = 1'b1;
        r_fin   = complete;
        r_seqno = seq_q;
        r_ackno = contig_d;
        r_stamp = stamp_q;
      end
    end

    // hold everything unless the word is processed
    if (!go) begin
      hs_d        = hs_q;
      seen_d      = seen_q;
      done_d      = done_q;
      peer_addr_d = peer_addr_q;
      peer_port_d = peer_port_q;
      base_d      = base_q;
      contig_d    = contig_q;
      fin_valid_d = fin_valid_q;
      fin_num_d   = fin_num_q;
      dup_d       = dup_q;
      win_ctl     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q        <= 1'b1;
      seen_q      <= 1'b0;
      done_q      <= 1'b0;
      peer_addr_q <= '0;
      peer_port_q <= '0;
      base_q      <= 1'b0;
      contig_q    <= '0;
      fin_valid_q <= 1'b0;
      fin_num_q   <= '0;
      dup_q       <= '0;
    end else begin
      hs_q        <= hs_d;
      seen_q      <= seen_d;
      done_q      <= done_d;
      peer_addr_q <= peer_addr_d;
      peer_port_q <= peer_port_d;
      base_q      <= base_d;
      contig_q    <= contig_d;
      fin_valid_q <= fin_valid_d;
      fin_num_q   <= fin_num_d;
      dup_q       <= dup_d;
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      send_ack_o        <= r_ack;
      reply_syn_o       <= r_syn;
      reply_fin_o       <= r_fin;
      reply_seqno_o     <= r_seqno;
      reply_ackno_o     <= r_ackno;
      stamp_echo_o      <= r_stamp;
      status_o          <= r_status;
      duplicate_total_o <= dup_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/trwa_checker.sv -----
// Port-level checks of the receive window acknowledger, bound to the top level
module trwa_checker
  import trwa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        send_ack_o,
  input logic        reply_syn_o,
  input logic        reply_fin_o,
  input logic [30:0] reply_seqno_o,
  input logic [30:0] reply_ackno_o,
  input logic [62:0] stamp_echo_o,
  input logic [3:0]  status_o,
  input logic [31:0] duplicate_total_o
);

`include "transport_receive_window_acker_assert.svh"

  // a stalled result word stays valid with its status and duplicate total held
  `TRWA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(duplicate_total_o), "result word changed while stalled")

  // no reply means empty reply fields
  `TRWA_ASSERT(a_quiet_fields, out_valid_o && !send_ack_o |-> !reply_syn_o && !reply_fin_o && reply_seqno_o == '0 && reply_ackno_o == '0 && stamp_echo_o == '0, "reply fields set without an ack")

  // SYN replies go with the synack status only, and always send
  `TRWA_ASSERT(a_syn_status, out_valid_o |-> (reply_syn_o == (status_o == StSynAck)) && (!reply_syn_o || send_ack_o), "SYN flag and status disagree")

  // FIN only on an acknowledged data word
  `TRWA_ASSERT(a_fin_data, out_valid_o && reply_fin_o |-> send_ack_o && (status_o == StNew || status_o == StDup || status_o == StOutWindow), "FIN on a word that is not data")

  // status stays in its code range, also around reset
  `TRWA_ASSERT_RST(a_status_range, !rst_ni || !out_valid_o || status_o <= StAfterDone, "status code out of range")

endmodule

bind transport_receive_window_acker trwa_checker u_trwa_checker (.*);
